/* sv/tcns_pkg.sv */
// Package for the theta Crank-Nicolson stencil: job and config types, codes,
// arithmetic widths and small helper functions. No dependencies.
`default_nettype none

package tcns_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LAP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_MODE  = 3'd4;

  // Job queue depth between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Product accumulator width: 40 bit by 60 bit magnitudes.
  localparam int unsigned ACC_W = 100;
  localparam logic [ACC_W-1:0] TERM_LIM = ACC_W'(1) << 59;

  typedef enum logic [1:0] {
    JOB_ZERO,
    JOB_POLE,
    JOB_FULL
  } job_kind_e;

  typedef enum logic [2:0] {
    OP_LAP,
    OP_CD,
    OP_GRAD,
    OP_CI,
    OP_CEN,
    OP_ROT
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_MUL,
    BK_SCALE,
    BK_ACC,
    BK_FINISH
  } bk_state_e;

  // One result to be computed. Samples are packed re low, im high.
  typedef struct packed {
    job_kind_e          kind;
    logic [63:0]        p;
    logic [63:0]        pm;
    logic [63:0]        pp;
    logic signed [39:0] cot;
    logic [39:0]        isn;
    logic               last;
    logic               err;
  } job_t;

  typedef struct packed {
    logic signed [31:0] lap_gain;
    logic signed [31:0] grad_gain;
    logic signed [31:0] cent_gain;
    logic signed [31:0] rot_gain;
    logic               pole_mode;
  } cfg_t;

  // Magnitude of a signed value whose magnitude fits in 60 bits.
  function automatic logic [59:0] mag_of(input logic signed [60:0] v);
    logic signed [60:0] n;
    n = -v;
    return v[60] ? n[59:0] : v[59:0];
  endfunction

  // Saturate to 32 bits; the top bit of the result is the clip flag.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/theta_crank_nicolson_stencil.sv */
// An interior point runs 12 terms on the shared 32x32 multiplier (four partial
// products per term); a pole point runs 2. The back works on one job at a time
// while a four-job queue takes further items. Reset clears window, position,
// registers, queue and output valid.
`default_nettype none

module theta_crank_nicolson_stencil
  import tcns_pkg::*;
#(
  parameter int unsigned MAX_ROW_LENGTH = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Configuration write port
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [31:0]          cfg_wdata_i,
  // Input items
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // psi_re[31:0], psi_im[63:32], cot_theta[103:64], inv_sin_sq[143:104]
  input  wire [143:0]         s_axis_tdata,
  input  wire                 s_axis_tlast,
  // Result items
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // out_re[31:0], out_im[63:32]
  output logic [63:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  // saturated[0], row_error[1]
  output logic [1:0]          m_axis_tuser
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;
  logic out_sat, out_err;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LAP_GAIN:  cfg_q.lap_gain  <= cfg_wdata_i;
        REG_GRAD_GAIN: cfg_q.grad_gain <= cfg_wdata_i;
        REG_CENT_GAIN: cfg_q.cent_gain <= cfg_wdata_i;
        REG_ROT_GAIN:  cfg_q.rot_gain  <= cfg_wdata_i;
        REG_POLE_MODE: cfg_q.pole_mode <= cfg_wdata_i[0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  tcns_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pole_mode_i (cfg_q.pole_mode),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[63:0]),
    .in_cot_i    (s_axis_tdata[103:64]),
    .in_isn_i    (s_axis_tdata[143:104]),
    .in_last_i   (s_axis_tlast),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  tcns_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  tcns_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_re_o   (m_axis_tdata[31:0]),
    .out_im_o   (m_axis_tdata[63:32]),
    .out_last_o (m_axis_tlast),
    .out_sat_o  (out_sat),
    .out_err_o  (out_err)
  );

  assign m_axis_tuser = {out_err, out_sat};

endmodule

`default_nettype wire

/* sv/tcns_queue.sv */
// Short job queue between the stencil front and the arithmetic back.
// Depends on tcns_pkg for the job type and the depth.
`default_nettype none

module tcns_queue
  import tcns_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  wire  pop_ready_i,
  output job_t pop_data_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/tcns_front.sv */
// Stencil front: keeps the two-sample window and row position, classifies each
// item into zero, pole or interior jobs and pushes them to the queue. Uses tcns_pkg.
`default_nettype none

module tcns_front
  import tcns_pkg::*;
#(
  parameter int unsigned MAX_ROW_LENGTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         pole_mode_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [63:0] in_sample_i,
  input  wire  [39:0] in_cot_i,
  input  wire  [39:0] in_isn_i,
  input  wire         in_last_i,
  output logic        push_valid_o,
  input  wire         push_ready_i,
  output job_t        push_data_o
);

  localparam int unsigned POS_W = $clog2(MAX_ROW_LENGTH);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ROW_LENGTH - 1);

  logic [63:0]      older_q, newer_q;
  logic [39:0]      newer_cot_q, newer_isn_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             pend_valid_q, pend_valid_d;
  job_t             pend_q;
  job_t             job_a, job_l;
  logic             job_a_v, job_l_v;
  logic             accept, short_row;

  assign in_ready_o = !pend_valid_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign short_row  = in_last_i && (pos_q < POS_W'(3));

  // Classify the item: a job for the point one behind, and one for the last point.
  always_comb begin
    job_a   = '0;
    job_l   = '0;
    job_a_v = 1'b0;
    job_l_v = in_last_i;
    if (short_row) begin
      job_a_v    = (pos_q != '0);
      job_a.kind = JOB_ZERO;
      job_a.err  = 1'b1;
      job_l.kind = JOB_ZERO;
      job_l.err  = 1'b1;
      job_l.last = 1'b1;
    end else begin
      if (pos_q == POS_W'(1)) begin
        job_a_v = 1'b1;
        if (!pole_mode_i) begin
          job_a.kind = JOB_POLE;
          job_a.p    = newer_q;
          job_a.pm   = in_sample_i;
          job_a.pp   = in_sample_i;
        end
      end else if (pos_q >= POS_W'(2)) begin
        job_a_v    = 1'b1;
        job_a.kind = JOB_FULL;
        job_a.p    = newer_q;
        job_a.pm   = (pole_mode_i && pos_q == POS_W'(2)) ? 64'd0 : older_q;
        job_a.pp   = (pole_mode_i && in_last_i) ? 64'd0 : in_sample_i;
        job_a.cot  = newer_cot_q;
        job_a.isn  = newer_isn_q;
      end
      job_l.last = 1'b1;
      if (!pole_mode_i) begin
        job_l.kind = JOB_POLE;
        job_l.p    = in_sample_i;
        job_l.pm   = newer_q;
        job_l.pp   = newer_q;
      end
    end
  end

  // Queue push: a held second job first, else the item's first job.
  always_comb begin
    push_valid_o = pend_valid_q || (accept && (job_a_v || job_l_v));
    if (pend_valid_q) begin
      push_data_o = pend_q;
    end else if (job_a_v) begin
      push_data_o = job_a;
    end else begin
      push_data_o = job_l;
    end
  end

  // Pending slot and row position.
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept && job_a_v && job_l_v) begin
      pend_valid_d = 1'b1;
    end else if (pend_valid_q && push_ready_i) begin
      pend_valid_d = 1'b0;
    end
    pos_d = pos_q;
    if (accept) begin
      if (in_last_i) begin
        pos_d = '0;
      end else if (pos_q < POS_MAX) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pos_q        <= '0;
      older_q      <= '0;
      newer_q      <= '0;
      newer_cot_q  <= '0;
      newer_isn_q  <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pos_q        <= pos_d;
      if (accept) begin
        older_q     <= newer_q;
        newer_q     <= in_sample_i;
        newer_cot_q <= in_cot_i;
        newer_isn_q <= in_isn_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && job_a_v && job_l_v) begin
      pend_q <= job_l;
    end
  end

endmodule

`default_nettype wire

/* sv/tcns_back.sv */
// Stencil back: evaluates queued jobs term by term on one shared 32x32
// multiplier, saturates and holds the result in an output register. Uses tcns_pkg.
`default_nettype none

module tcns_back
  import tcns_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  input  wire         job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] out_re_o,
  output logic [31:0] out_im_o,
  output logic        out_last_o,
  output logic        out_sat_o,
  output logic        out_err_o
);

  bk_state_e          state_q, state_d;
  job_t               job_q;
  op_e                op_q, op_next;
  logic               comp_q;
  logic [2:0]         dig_q;
  logic [39:0]        a_q;
  logic [59:0]        b_q;
  logic               neg_q, long_q;
  logic [63:0]        prod_q;
  logic [1:0]         prod_sh_q;
  logic [ACC_W-1:0]   acc_q;
  logic signed [60:0] term_q, tcd_q, tci_q;
  logic signed [63:0] x_q, xr_q;
  logic               clip_q;
  logic               out_valid_q;
  logic [31:0]        out_re_q, out_im_q;
  logic               out_last_q, out_sat_q, out_err_q;

  logic               pop, out_load, op_last;
  logic signed [31:0] p_c, pm_c, pp_c;
  logic signed [33:0] d2;
  logic signed [32:0] d1;
  logic signed [60:0] a_val, b_val;
  logic [59:0]        a_mag, b_mag;
  logic               long_sel;
  logic [31:0]        a_dig, b_dig;
  logic [ACC_W-1:0]   prod_ext, scaled;
  logic               over;
  logic [60:0]        tmag;
  logic signed [63:0] x_new, neg_x;
  logic [32:0]        sat_re, sat_im;

  // Control outputs of the sequencer.
  always_comb begin
    pop      = (state_q == BK_IDLE) && job_valid_i;
    out_load = (state_q == BK_FINISH) && (!out_valid_q || out_ready_i);
    op_last  = (job_q.kind == JOB_POLE) || (op_q == OP_ROT);
  end

  assign job_ready_o = (state_q == BK_IDLE);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          state_d = (job_i.kind == JOB_ZERO) ? BK_FINISH : BK_SETUP;
        end
      end
      BK_SETUP:  state_d = BK_MUL;
      BK_MUL: begin
        if (dig_q == 3'd4) begin
          state_d = BK_SCALE;
        end
      end
      BK_SCALE:  state_d = BK_ACC;
      BK_ACC: begin
        if (op_last && comp_q) begin
          state_d = BK_FINISH;
        end else begin
          state_d = BK_SETUP;
        end
      end
      BK_FINISH: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  // Next term in the interior sequence.
  always_comb begin
    case (op_q)
      OP_LAP:  op_next = OP_CD;
      OP_CD:   op_next = OP_GRAD;
      OP_GRAD: op_next = OP_CI;
      OP_CI:   op_next = OP_CEN;
      OP_CEN:  op_next = OP_ROT;
      default: op_next = OP_LAP;
    endcase
  end

  // Operand selection for the current component and term.
  always_comb begin
    p_c  = comp_q ? job_q.p[63:32]  : job_q.p[31:0];
    pm_c = comp_q ? job_q.pm[63:32] : job_q.pm[31:0];
    pp_c = comp_q ? job_q.pp[63:32] : job_q.pp[31:0];
    d2   = 34'(pp_c) - 34'(p_c) - 34'(p_c) + 34'(pm_c);
    d1   = 33'(pp_c) - 33'(pm_c);
    case (op_q)
      OP_LAP: begin
        a_val    = 61'(cfg_i.lap_gain);
        b_val    = 61'(d2);
        long_sel = 1'b1;
      end
      OP_CD: begin
        a_val    = 61'(job_q.cot);
        b_val    = 61'(d1);
        long_sel = 1'b0;
      end
      OP_GRAD: begin
        a_val    = 61'(cfg_i.grad_gain);
        b_val    = tcd_q;
        long_sel = 1'b1;
      end
      OP_CI: begin
        a_val    = 61'({1'b0, job_q.isn});
        b_val    = 61'(p_c);
        long_sel = 1'b0;
      end
      OP_CEN: begin
        a_val    = 61'(cfg_i.cent_gain);
        b_val    = tci_q;
        long_sel = 1'b1;
      end
      OP_ROT: begin
        a_val    = 61'(cfg_i.rot_gain);
        b_val    = 61'(p_c);
        long_sel = 1'b1;
      end
      default: begin
        a_val    = '0;
        b_val    = '0;
        long_sel = 1'b1;
      end
    endcase
    a_mag = mag_of(a_val);
    b_mag = mag_of(b_val);
  end

  // Partial product digits and alignment.
  always_comb begin
    a_dig = dig_q[1] ? 32'(a_q[39:32]) : a_q[31:0];
    b_dig = dig_q[0] ? 32'(b_q[59:32]) : b_q[31:0];
    case (prod_sh_q)
      2'd0:    prod_ext = ACC_W'(prod_q);
      2'd1:    prod_ext = ACC_W'({prod_q, 32'd0});
      default: prod_ext = ACC_W'({prod_q, 64'd0});
    endcase
  end

  // Rounded product scaled to Q.30, clamped, then signed.
  always_comb begin
    scaled = long_q ? (acc_q >> 24) : (acc_q >> 16);
    over   = (scaled > TERM_LIM);
    tmag   = over ? 61'(TERM_LIM) : {1'b0, scaled[59:0]};
  end

  // Term accumulation into the component sum.
  always_comb begin
    case (op_q)
      OP_LAP:  x_new = x_q - 64'(term_q);
      OP_GRAD: x_new = x_q - 64'(term_q);
      OP_CEN:  x_new = x_q + 64'(term_q);
      OP_ROT:  x_new = x_q + 64'(term_q);
      default: x_new = x_q;
    endcase
  end

  // Final saturation: out_re = -Xim, out_im = Xre.
  always_comb begin
    neg_x  = -x_q;
    sat_re = sat32(neg_x);
    sat_im = sat32(xr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          job_q  <= job_i;
          comp_q <= 1'b0;
          op_q   <= OP_LAP;
          clip_q <= 1'b0;
          x_q    <= '0;
          xr_q   <= '0;
        end
      end
      BK_SETUP: begin
        a_q    <= a_mag[39:0];
        b_q    <= b_mag;
        neg_q  <= a_val[60] ^ b_val[60];
        long_q <= long_sel;
        acc_q  <= long_sel ? (ACC_W'(1) << 23) : (ACC_W'(1) << 15);
        dig_q  <= '0;
        if (op_q == OP_LAP) begin
          x_q <= 64'(p_c);
        end
      end
      BK_MUL: begin
        if (!dig_q[2]) begin
          prod_q    <= 64'(a_dig) * 64'(b_dig);
          prod_sh_q <= {1'b0, dig_q[1]} + {1'b0, dig_q[0]};
        end
        if (dig_q != 3'd0) begin
          acc_q <= acc_q + prod_ext;
        end
        dig_q <= dig_q + 1'b1;
      end
      BK_SCALE: begin
        term_q <= neg_q ? -$signed(tmag) : $signed(tmag);
        clip_q <= clip_q | over;
      end
      BK_ACC: begin
        x_q <= x_new;
        if (op_q == OP_CD) begin
          tcd_q <= term_q;
        end
        if (op_q == OP_CI) begin
          tci_q <= term_q;
        end
        if (!op_last) begin
          op_q <= op_next;
        end else if (!comp_q) begin
          xr_q   <= x_new;
          comp_q <= 1'b1;
          op_q   <= OP_LAP;
        end
      end
      BK_FINISH: begin
        if (out_load) begin
          out_re_q   <= sat_re[31:0];
          out_im_q   <= sat_im[31:0];
          out_last_q <= job_q.last;
          out_sat_q  <= clip_q | sat_re[32] | sat_im[32];
          out_err_q  <= job_q.err;
        end
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_last_o  = out_last_q;
  assign out_sat_o   = out_sat_q;
  assign out_err_o   = out_err_q;

endmodule

`default_nettype wire
